// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions of the RTL blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ate_pkg.sv =====
// ---------------------------------------------------------------------------
// ate_pkg
// Types, widths and request codes of the affine transform engine.
// ---------------------------------------------------------------------------
package ate_pkg;

    // Field widths
    localparam int REQ_W     = 2;
    localparam int IDX_W     = 4;
    localparam int FIX_W     = 32;
    localparam int NUM_ELEM  = 12;
    localparam int PROD_W    = 2 * FIX_W;

    // Stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 96;

    // Default fraction width of the Q format
    localparam int FRAC_BITS_DEF = 16;

    // Request codes carried in s_tuser
    localparam logic [REQ_W-1:0] REQ_WRITE_A   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_B   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPOSE   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TRANSFORM = 2'd3;

    // Signed fixed-point element
    typedef logic signed [FIX_W-1:0] fix_t;

    // Saturation bounds of an element
    localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
    localparam fix_t FIX_MIN = 32'sh8000_0000;

endpackage

// ===== src/affine_transform_engine.sv =====
// ---------------------------------------------------------------------------
// affine_transform_engine
// Two 3x4 Q-format affine matrices with element writes, composition A := A*B
// and point transform; compose and transform share one multiply-accumulate unit.
// ---------------------------------------------------------------------------
// Rate: the block takes one item at a time; s_tready is low while it works.
// An element write is stored on acceptance and the block stays idle. Every output
// element runs through the one 32x32 signed multiplier and its accumulator in order:
// load offset, three multiply/accumulate pairs, saturate. A point transform works
// out three elements and then waits until the output register is free; a compose
// works out all twelve elements of A, written back a row at a time. Products
// are truncated toward zero, sums saturate to 32 bits, and m_tuser flags a
// clipped coordinate.
// ---------------------------------------------------------------------------
module affine_transform_engine #(
    parameter int FRAC_BITS = ate_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: elem_index[3:0], elem_value[35:4], point_x[67:36],
    //          point_y[99:68], point_z[131:100], zero pad[135:132]
    input  logic [ate_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [ate_pkg::REQ_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [ate_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: saturated[0]
    output logic                          m_tuser
);
    import ate_pkg::*;

    localparam int SH_W  = PROD_W - FRAC_BITS;
    localparam int ACC_W = SH_W + 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-FIX_W+1){1'b0}}, {(FIX_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-FIX_W+1){1'b1}}, {(FIX_W-1){1'b0}}};

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;
    localparam logic [2:0] ST_HOLD = 3'd5;

    localparam logic [1:0] LAST_TERM = 2'd2;
    localparam logic [1:0] LAST_ROW  = 2'd2;
    localparam logic [1:0] LAST_COL  = 2'd3;

    // Input field views
    logic [IDX_W-1:0] in_idx;
    fix_t             in_val;
    fix_t             in_px;
    fix_t             in_py;
    fix_t             in_pz;

    assign in_idx = s_tdata[3:0];
    assign in_val = s_tdata[35:4];
    assign in_px  = s_tdata[67:36];
    assign in_py  = s_tdata[99:68];
    assign in_pz  = s_tdata[131:100];

    // Storage
    fix_t mat_a_reg [NUM_ELEM];
    fix_t mat_b_reg [NUM_ELEM];
    fix_t point_reg [3];
    fix_t coord_reg [3];
    fix_t rowbuf_reg [3];
    logic compose_ovf_reg;

    // Sequencer and datapath registers
    logic [2:0]                state_reg;
    logic                      is_compose_reg;
    logic [1:0]                row_reg;
    logic [1:0]                col_reg;
    logic [1:0]                k_reg;
    logic                      clip_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic                      m_tuser_reg;

    logic                      s_fire;
    logic                      out_free;
    logic [IDX_W-1:0]          a_addr;
    fix_t                      a_opnd;
    fix_t                      b_opnd;
    fix_t                      bias;
    logic [SH_W-1:0]           prod_sh;
    logic                      prod_corr;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      sat_hi;
    logic                      sat_lo;
    fix_t                      sat_val;
    logic                      clip_next;
    logic                      fin_compose;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Select operands: one read of A per cycle, offset column in ST_INIT
    assign a_addr = (state_reg == ST_INIT) ? {row_reg, 2'd3} : {row_reg, k_reg};
    assign a_opnd = mat_a_reg[a_addr];
    assign b_opnd = is_compose_reg ? mat_b_reg[{k_reg, col_reg}] : point_reg[k_reg];
    assign bias   = (!is_compose_reg || (col_reg == LAST_COL)) ? a_opnd : '0;

    // Truncate product toward zero: floor shift plus one for a negative inexact value
    assign prod_sh   = prod_reg[PROD_W-1:FRAC_BITS];
    assign prod_corr = prod_reg[PROD_W-1] && (|prod_reg[FRAC_BITS-1:0]);
    assign acc_next  = acc_reg + $signed({{2{prod_sh[SH_W-1]}}, prod_sh})
                     + $signed({{(ACC_W-1){1'b0}}, prod_corr});

    // Saturate the finished sum
    always_comb begin
        sat_hi = (acc_reg > ACC_MAX);
        sat_lo = (acc_reg < ACC_MIN);
        priority if (sat_hi) begin
            sat_val = FIX_MAX;
        end else if (sat_lo) begin
            sat_val = FIX_MIN;
        end else begin
            sat_val = acc_reg[FIX_W-1:0];
        end
        clip_next = clip_reg || sat_hi || sat_lo;
    end

    assign fin_compose = (state_reg == ST_SAT) && is_compose_reg
                      && (col_reg == LAST_COL) && (row_reg == LAST_ROW);

    // Matrix store: host writes and compose write-back, row at a time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ELEM; i++) begin
                mat_a_reg[i] <= '0;
                mat_b_reg[i] <= '0;
            end
            compose_ovf_reg <= 1'b0;
        end else begin
            if (s_fire && (in_idx < IDX_W'(NUM_ELEM))) begin
                if (s_tuser == REQ_WRITE_A) begin
                    mat_a_reg[in_idx] <= in_val;
                end
                if (s_tuser == REQ_WRITE_B) begin
                    mat_b_reg[in_idx] <= in_val;
                end
            end
            if ((state_reg == ST_SAT) && is_compose_reg && (col_reg == LAST_COL)) begin
                mat_a_reg[{row_reg, 2'd0}] <= rowbuf_reg[0];
                mat_a_reg[{row_reg, 2'd1}] <= rowbuf_reg[1];
                mat_a_reg[{row_reg, 2'd2}] <= rowbuf_reg[2];
                mat_a_reg[{row_reg, 2'd3}] <= sat_val;
            end
            if (fin_compose) begin
                compose_ovf_reg <= clip_next;
            end
        end
    end

    // Payload registers: point, per-element results, product, accumulator, output data
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            point_reg[0] <= in_px;
            point_reg[1] <= in_py;
            point_reg[2] <= in_pz;
        end
        if (state_reg == ST_INIT) begin
            acc_reg <= $signed({{(ACC_W-FIX_W){bias[FIX_W-1]}}, bias});
        end else if (state_reg == ST_ACC) begin
            acc_reg <= acc_next;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= a_opnd * b_opnd;
        end
        if (state_reg == ST_SAT) begin
            if (is_compose_reg) begin
                if (col_reg != LAST_COL) begin
                    rowbuf_reg[col_reg] <= sat_val;
                end
            end else begin
                coord_reg[row_reg] <= sat_val;
            end
        end
        if ((state_reg == ST_HOLD) && out_free) begin
            m_tdata_reg <= {coord_reg[2], coord_reg[1], coord_reg[0]};
            m_tuser_reg <= clip_reg;
        end
    end

    // Sequencer: rows, columns and terms of one request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            is_compose_reg <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            k_reg          <= '0;
            clip_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // Raise valid on a new result, drop it once the item is taken
            if ((state_reg == ST_HOLD) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && ((s_tuser == REQ_COMPOSE) || (s_tuser == REQ_TRANSFORM))) begin
                        is_compose_reg <= (s_tuser == REQ_COMPOSE);
                        row_reg        <= '0;
                        col_reg        <= '0;
                        clip_reg       <= 1'b0;
                        state_reg      <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    k_reg     <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (k_reg == LAST_TERM) begin
                        state_reg <= ST_SAT;
                    end else begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_SAT: begin
                    clip_reg <= clip_next;
                    if (is_compose_reg) begin
                        if (col_reg == LAST_COL) begin
                            col_reg <= '0;
                            if (row_reg == LAST_ROW) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                row_reg   <= row_reg + 2'd1;
                                state_reg <= ST_INIT;
                            end
                        end else begin
                            col_reg   <= col_reg + 2'd1;
                            state_reg <= ST_INIT;
                        end
                    end else if (row_reg == LAST_ROW) begin
                        state_reg <= ST_HOLD;
                    end else begin
                        row_reg   <= row_reg + 2'd1;
                        state_reg <= ST_INIT;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
`include "assert_macros.svh"

    `ASSERT_IMPL(a_load_free, aclk, aresetn, (state_reg == ST_HOLD) && out_free && m_tvalid_reg, m_tready, "result loaded over an untaken result")
    `ASSERT_IMPL(a_term_range, aclk, aresetn, (state_reg == ST_MUL) || (state_reg == ST_ACC), k_reg != 2'd3, "term counter out of range")
    `ASSERT_NEXT(a_ovf_track, aclk, aresetn, fin_compose, compose_ovf_reg == $past(clip_next), "compose overflow flag not updated")
    `ASSERT_IMPL(a_sat_bound, aclk, aresetn, m_tvalid && m_tuser, (m_tdata[31:0] == FIX_MAX) || (m_tdata[31:0] == FIX_MIN) || (m_tdata[63:32] == FIX_MAX) || (m_tdata[63:32] == FIX_MIN) || (m_tdata[95:64] == FIX_MAX) || (m_tdata[95:64] == FIX_MIN), "saturated flag without a clipped coordinate")

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for affine_transform_engine
// Streams element writes, compositions and point transforms into the engine,
// keeps a bit-exact software copy of both matrices to predict every returned
// point, and checks each result in order while both stream sides idle at
// random and the result side is held off for long stretches.
// ----------------------------------------------------------------------------
module tb_top;
    import ate_pkg::*;

    localparam int     FRAC        = FRAC_BITS_DEF;
    localparam longint PROD_SCALE  = longint'(1) <<< FRAC;
    localparam fix_t   FIX_ONE     = fix_t'(longint'(1) <<< FRAC);
    localparam int     ITEM_TARGET = 1700;
    localparam int     HOLD_AT     = 450;
    localparam int     HOLD_LEN    = 400;
    localparam int     DRAIN_WAIT  = 150;
    localparam int     CYCLE_LIMIT = 1_500_000;

    // One request as it travels on the input stream
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] idx;
        fix_t             value;
        fix_t             px;
        fix_t             py;
        fix_t             pz;
    } xform_req_t;

    // One transformed point
    typedef struct packed {
        fix_t x;
        fix_t y;
        fix_t z;
        logic sat;
    } xform_res_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // s_tdata: elem_index[3:0], elem_value[35:4], point_x[67:36],
    //          point_y[99:68], point_z[131:100], zero pad[135:132]
    logic [S_TDATA_W-1:0] s_tdata;
    // s_tuser: req_type[1:0]
    logic [REQ_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // m_tdata: out_x[31:0], out_y[63:32], out_z[95:64]
    logic [M_TDATA_W-1:0] m_tdata;
    // m_tuser: saturated[0]
    logic                 m_tuser;

    // Predicted engine state
    fix_t mat_a [NUM_ELEM];
    fix_t mat_b [NUM_ELEM];
    bit   compose_clipped;

    xform_req_t pending_reqs[$];
    xform_res_t expected_points[$];
    xform_req_t cur_req;

    bit          item_taken;
    int          gap_left, calm_tx;
    int          stall_left, calm_rx, hold_left, holds_done;
    int unsigned n_queued, n_taken, n_writes, n_composes, n_transforms;
    int unsigned n_checked, n_saturated, mismatches, cycle_count;

    affine_transform_engine #(
        .FRAC_BITS (FRAC)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock: period 10
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point prediction
    // ------------------------------------------------------------------

    // Exact product scaled back by the fraction width, truncated toward zero
    function automatic longint scaled_product(fix_t a, fix_t b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return prod / PROD_SCALE;
    endfunction

    function automatic bit out_of_range(longint v);
        return (v > longint'(FIX_MAX)) || (v < longint'(FIX_MIN));
    endfunction

    function automatic fix_t clip_fix(longint v);
        if (v > longint'(FIX_MAX))
            return FIX_MAX;
        if (v < longint'(FIX_MIN))
            return FIX_MIN;
        return fix_t'(v[31:0]);
    endfunction

    // Update the matrix copy for one accepted request; queue a point if one results
    function automatic void apply_request(xform_req_t rq);
        fix_t       nxt [NUM_ELEM];
        fix_t       pt [3];
        longint     acc;
        bit         clip;
        xform_res_t res;
        clip = 1'b0;
        case (rq.req)
            REQ_WRITE_A: begin
                if (rq.idx < NUM_ELEM)
                    mat_a[rq.idx] = rq.value;
            end
            REQ_WRITE_B: begin
                if (rq.idx < NUM_ELEM)
                    mat_b[rq.idx] = rq.value;
            end
            REQ_COMPOSE: begin
                // A := A*B with the implied bottom row (0,0,0,1)
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        acc = 0;
                        for (int k = 0; k < 3; k++)
                            acc += scaled_product(mat_a[r*4+k], mat_b[k*4+c]);
                        if (c == 3)
                            acc += longint'(mat_a[r*4+3]);
                        clip |= out_of_range(acc);
                        nxt[r*4+c] = clip_fix(acc);
                    end
                end
                for (int k = 0; k < NUM_ELEM; k++)
                    mat_a[k] = nxt[k];
                compose_clipped = clip;
            end
            default: begin
                pt[0] = rq.px;
                pt[1] = rq.py;
                pt[2] = rq.pz;
                for (int r = 0; r < 3; r++) begin
                    acc = longint'(mat_a[r*4+3]);
                    for (int k = 0; k < 3; k++)
                        acc += scaled_product(mat_a[r*4+k], pt[k]);
                    clip |= out_of_range(acc);
                    nxt[r] = clip_fix(acc);
                end
                res.x   = nxt[0];
                res.y   = nxt[1];
                res.z   = nxt[2];
                res.sat = clip;
                expected_points.push_back(res);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic fix_t rand_any();
        return fix_t'($urandom);
    endfunction

    function automatic fix_t rand_span(int span);
        return fix_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic fix_t rand_edge();
        case ($urandom_range(0, 7))
            0:       return FIX_MAX;
            1:       return FIX_MIN;
            2:       return fix_t'(0);
            3:       return fix_t'(1);
            4:       return fix_t'(-1);
            5:       return FIX_ONE;
            6:       return -FIX_ONE;
            default: return FIX_MAX - fix_t'(1);
        endcase
    endfunction

    // Matrix element: mostly within +/-4.0, some full range and corner values
    function automatic fix_t rand_elem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return rand_span(4 << FRAC);
        if (r < 70)
            return rand_any();
        if (r < 85)
            return rand_edge();
        return ($urandom_range(0, 1) != 0) ? FIX_ONE : -FIX_ONE;
    endfunction

    // Point coordinate: mostly within +/-1024.0
    function automatic fix_t rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return rand_span(1024 << FRAC);
        if (r < 85)
            return rand_any();
        return rand_edge();
    endfunction

    // Queue one item; writes to a missing element do not count
    function automatic void queue_item(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                       fix_t value, fix_t px, fix_t py, fix_t pz);
        xform_req_t rq;
        rq.req   = req;
        rq.idx   = idx;
        rq.value = value;
        rq.px    = px;
        rq.py    = py;
        rq.pz    = pz;
        pending_reqs.push_back(rq);
        if (!((req == REQ_WRITE_A || req == REQ_WRITE_B) && idx >= NUM_ELEM))
            n_queued++;
    endfunction

    function automatic void queue_write(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                        fix_t value);
        queue_item(req, idx, value, rand_any(), rand_any(), rand_any());
    endfunction

    function automatic void queue_point(fix_t px, fix_t py, fix_t pz);
        queue_item(REQ_TRANSFORM, IDX_W'($urandom), rand_any(), px, py, pz);
    endfunction

    function automatic void queue_compose();
        queue_item(REQ_COMPOSE, IDX_W'($urandom), rand_any(), rand_any(), rand_any(),
                   rand_any());
    endfunction

    // Write all twelve elements: random, near-identity or corner-heavy
    function automatic void queue_matrix(logic [REQ_W-1:0] req);
        int   style;
        fix_t v;
        style = $urandom_range(0, 3);
        for (int i = 0; i < NUM_ELEM; i++) begin
            if (style == 0) begin
                if (i == 0 || i == 5 || i == 10)
                    v = FIX_ONE + rand_span(FIX_ONE / 4);
                else if (i % 4 == 3)
                    v = rand_span(64 << FRAC);
                else
                    v = rand_span(FIX_ONE / 4);
            end else if (style == 1) begin
                v = rand_elem();
            end else begin
                v = rand_span(2 << FRAC);
            end
            queue_write(req, IDX_W'(i), v);
        end
    endfunction

    // One well-formed sequence with random content, or a little noise
    function automatic void queue_sequence();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 18) begin
            queue_matrix(REQ_WRITE_A);
        end else if (kind < 30) begin
            queue_matrix(REQ_WRITE_B);
        end else if (kind < 40) begin
            repeat ($urandom_range(1, 3))
                queue_write(($urandom_range(0, 1) != 0) ? REQ_WRITE_A : REQ_WRITE_B,
                            IDX_W'($urandom_range(0, 15)), rand_elem());
        end else if (kind < 50) begin
            queue_compose();
            repeat ($urandom_range(1, 4))
                queue_point(rand_coord(), rand_coord(), rand_coord());
        end else if (kind < 95) begin
            repeat ($urandom_range(1, 10))
                queue_point(rand_coord(), rand_coord(), rand_coord());
        end else begin
            repeat ($urandom_range(1, 3))
                queue_item(REQ_W'($urandom), IDX_W'($urandom), rand_any(), rand_any(),
                           rand_any(), rand_any());
        end
    endfunction

    // Directed items: corner values, every request, ignored writes
    function automatic void queue_directed();
        // matrices are all zero after reset
        queue_point(FIX_ONE, FIX_MAX, FIX_MIN);
        // positive saturation on row 0
        queue_write(REQ_WRITE_A, 0, FIX_MAX);
        queue_write(REQ_WRITE_A, 3, FIX_MAX);
        queue_point(FIX_MAX, rand_any(), rand_any());
        // tiny negative product must truncate toward zero, not to -1
        queue_write(REQ_WRITE_A, 0, fix_t'(-1));
        queue_write(REQ_WRITE_A, 3, fix_t'(0));
        queue_point(fix_t'(1), rand_any(), rand_any());
        queue_point(fix_t'(-1), rand_any(), rand_any());
        // negative saturation on row 1
        queue_write(REQ_WRITE_A, 4, FIX_MIN);
        queue_write(REQ_WRITE_A, 7, FIX_MIN);
        queue_point(FIX_MAX, FIX_MIN, FIX_MAX);
        // writes past the last element leave both matrices alone
        queue_write(REQ_WRITE_A, 12, FIX_MAX);
        queue_write(REQ_WRITE_B, 15, FIX_MIN);
        queue_point(FIX_MAX, FIX_MIN, FIX_MAX);
        // compose with corner values in B
        queue_write(REQ_WRITE_B, 0, FIX_ONE);
        queue_write(REQ_WRITE_B, 5, FIX_ONE);
        queue_write(REQ_WRITE_B, 10, FIX_MIN);
        queue_write(REQ_WRITE_B, 11, FIX_MAX);
        queue_compose();
        queue_point(FIX_MIN, FIX_MAX, FIX_MIN);
        // a second compose on the first compose's result
        queue_write(REQ_WRITE_A, 8, FIX_ONE / 2);
        queue_compose();
        queue_point(FIX_MAX, FIX_MAX, FIX_MAX);
        queue_item(REQ_WRITE_A, 4'hF, fix_t'(-1), fix_t'(-1), fix_t'(-1), fix_t'(-1));
        queue_point(fix_t'(0), fix_t'(0), fix_t'(0));
    endfunction

    // ------------------------------------------------------------------
    // Input side: driver and acceptance monitor
    // ------------------------------------------------------------------

    // Hold the current item until taken, then advance after a random gap
    always @(negedge aclk) begin
        logic offer;
        offer = (s_tvalid === 1'b1) && !item_taken;
        item_taken = 1'b0;
        if (aresetn && !offer) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                offer = 1'b1;
                if (calm_tx > 0) begin
                    calm_tx--;
                end else begin
                    gap_left = pick_idle();
                    if ($urandom_range(0, 99) == 0)
                        calm_tx = $urandom_range(20, 120);
                end
            end
        end
        s_tvalid <= offer;
        s_tuser  <= cur_req.req;
        s_tdata  <= {4'b0, cur_req.pz, cur_req.py, cur_req.px, cur_req.value, cur_req.idx};
    end

    // Predict from what the engine actually took
    always @(posedge aclk) begin
        xform_req_t rq;
        if (aresetn && s_tvalid && s_tready) begin
            rq.req   = s_tuser;
            rq.idx   = s_tdata[3:0];
            rq.value = s_tdata[35:4];
            rq.px    = s_tdata[67:36];
            rq.py    = s_tdata[99:68];
            rq.pz    = s_tdata[131:100];
            apply_request(rq);
            item_taken = 1'b1;
            n_taken++;
            case (rq.req)
                REQ_WRITE_A, REQ_WRITE_B: n_writes++;
                REQ_COMPOSE:              n_composes++;
                default:                  n_transforms++;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result side: receiver and checker
    // ------------------------------------------------------------------

    // Random stalls, calm stretches, and a few long hold-offs to back up the engine
    always @(negedge aclk) begin
        logic rdy;
        if (hold_left == 0 && holds_done < 3 && n_taken >= HOLD_AT * (holds_done + 1)) begin
            hold_left = HOLD_LEN;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
            if (calm_rx > 0)
                calm_rx--;
            else if ($urandom_range(0, 9) == 0)
                stall_left = pick_idle();
            else if ($urandom_range(0, 99) == 0)
                calm_rx = $urandom_range(30, 150);
        end
        m_tready <= rdy;
    end

    // Compare each returned point with the oldest prediction
    always @(posedge aclk) begin
        xform_res_t got, want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.x   = m_tdata[31:0];
            got.y   = m_tdata[63:32];
            got.z   = m_tdata[95:64];
            got.sat = m_tuser;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%h y=%h z=%h sat=%b",
                             got.x, got.y, got.z, got.sat);
            end else begin
                want = expected_points.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.sat !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point %0d: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                                 n_checked, want.x, want.y, want.z, want.sat,
                                 got.x, got.y, got.z, got.sat);
                end
                n_checked++;
                if (want.sat)
                    n_saturated++;
            end
        end
    end

    // End the run at a generous limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d points outstanding",
                     cycle_count, expected_points.size());
            $display("affine_transform_engine regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: fill, reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        cur_req  = '0;
        for (int k = 0; k < NUM_ELEM; k++) begin
            mat_a[k] = '0;
            mat_b[k] = '0;
        end
        compose_clipped = 1'b0;

        queue_directed();
        while (n_queued < ITEM_TARGET)
            queue_sequence();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // wait until every item is taken and every point has come back
        do
            @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_points.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("items taken: %0d (%0d writes, %0d composes, %0d transforms)",
                 n_taken, n_writes, n_composes, n_transforms);
        $display("points checked: %0d, %0d saturated, %0d mismatches, %0d cycles",
                 n_checked, n_saturated, mismatches, cycle_count);
        if (mismatches == 0)
            $display("affine_transform_engine regression: pass");
        else
            $display("affine_transform_engine regression: fail");
        $finish;
    end

endmodule
